/* hdl/frsl_pkg.sv */
// frsl_pkg: types, constants and helpers shared by the fresnel reflectance pipeline
// no dependencies; used by frsl_isqrt and fresnel_reflectance_unit

package frsl_pkg;

    // fraction bits of the direction and normal components
    localparam int VEC_FRAC_BITS = 14;

    localparam int PROD_FRAC = 2 * VEC_FRAC_BITS;
    localparam int COS_SHL   = (PROD_FRAC < 30) ? (30 - PROD_FRAC) : 0;
    localparam int COS_SHR   = (PROD_FRAC >= 30) ? (PROD_FRAC - 30) : 0;

    localparam logic [30:0] ONE30 = 31'h4000_0000;
    localparam logic [15:0] ONE15 = 16'h8000;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [14:0]        index_incident;
        logic [14:0]        index_transmit;
    } item_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } result_t;

    typedef struct packed {
        logic n2_zero;
        logic tir;
    } flags_t;

    // per-ray values that ride along the long divide and root stages
    typedef struct packed {
        logic [31:0] c30;
        logic [14:0] n1;
        logic [14:0] n2;
        flags_t      flg;
    } side_t;

    // dot product magnitude to Q1.30, saturated to one
    function automatic logic [30:0] cos_scale(input logic [33:0] mag);
        logic [63:0] w;
        w = ({30'd0, mag} << COS_SHL) >> COS_SHR;
        return (w > {33'd0, ONE30}) ? ONE30 : w[30:0];
    endfunction

endpackage

/* hdl/frsl_isqrt.sv */
// frsl_isqrt: pipelined integer square root, one root bit per stage
// depends on frsl_pkg (side_t)

module frsl_isqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [60:0]    in_rad,
    input  frsl_pkg::side_t in_side,
    output logic           out_valid,
    output logic [30:0]    out_root,
    output frsl_pkg::side_t out_side
);
    import frsl_pkg::*;

    localparam int STEPS = 31;

    logic        v_reg    [0:STEPS];
    logic [60:0] rem_reg  [0:STEPS];
    logic [60:0] root_reg [0:STEPS];
    side_t       side_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [60:0] BIT = 61'd1 << (2 * (STEPS - 1 - k));
        logic [60:0] trial;
        logic        take;
        logic [60:0] rem_next;
        logic [60:0] root_next;

        always_comb
        begin
            trial     = root_reg[k] + BIT;
            take      = rem_reg[k] >= trial;
            rem_next  = take ? (rem_reg[k] - trial) : rem_reg[k];
            root_next = take ? ((root_reg[k] >> 1) + BIT) : (root_reg[k] >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_root  = root_reg[STEPS][30:0];
    assign out_side  = side_reg[STEPS];

    // radicand is below 2^61 so the root never needs more than 31 bits
    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STEPS] |-> (root_reg[STEPS][60:31] == '0))
        else $error("square root overflowed 31 bits");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STEPS] |-> (rem_reg[STEPS] <= {root_reg[STEPS][59:0], 1'b0}))
        else $error("square root remainder too large");

endmodule

/* hdl/fresnel_reflectance_unit.sv */
// fresnel_reflectance_unit: unpolarized fresnel reflectance, fully pipelined
// depends on frsl_pkg and frsl_isqrt
//
// usage:
//   item channel (item_valid / item_ready / item) carries one ray beat: incident
//   direction and surface normal in signed Q1.14, two refractive indices in Q3.12.
//   result channel (result_valid / result_ready / result) returns one beat per ray:
//   reflectance in Q1.15 (32768 = 1.0) and the total internal reflection flag.
//   results leave in the order the rays came in.
// throughput: one ray per cycle unless the result stalls; no state between rays.
// pipeline: input register and front stages, then the 31-stage quotient divider,
//   the 31-stage square root and the 15-stage ratio dividers, each producing one
//   bit per stage, with operand and output registers between them.
// stall: while a result waits for result_ready the whole pipeline holds; the
//   input register still takes one more beat if it is empty.
// reset: rst_n clears all valid bits; the pipeline is empty and ready at once.

module fresnel_reflectance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  frsl_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output frsl_pkg::result_t result
);
    import frsl_pkg::*;

    localparam int QBITS = 31;
    localparam int RBITS = 15;

    logic    adv;
    logic    result_valid_reg;
    result_t result_reg;

    assign adv = !result_valid_reg || result_ready;

    // ---------------- input register
    logic  v0_reg;
    item_t item_reg;

    assign item_ready = adv || !v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            v0_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    // ---------------- front stages: dot product, cosine, sine squared operands
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [31:0] pxx_reg, pyy_reg, pzz_reg;
    logic [14:0]        n1_1_reg, n2_1_reg, n1_2_reg, n2_2_reg;
    logic [30:0]        cm_reg;
    logic               neg_reg;
    logic [61:0]        c2full_reg;
    logic [29:0]        n1sq3_reg, n2sq3_reg, n1sq4_reg, n2sq4_reg, den5_reg;
    side_t              side3_reg, side4_reg, side5_reg;
    logic [30:0]        om_reg;
    logic [60:0]        numr5_reg;

    logic signed [31:0] pxx_next, pyy_next, pzz_next;
    logic signed [33:0] dot;
    logic [33:0]        dot_mag;
    logic [30:0]        cm_next;
    logic               neg_next;
    side_t              side3_next;

    always_comb
    begin
        pxx_next = $signed(item_reg.dir_x) * $signed(item_reg.norm_x);
        pyy_next = $signed(item_reg.dir_y) * $signed(item_reg.norm_y);
        pzz_next = $signed(item_reg.dir_z) * $signed(item_reg.norm_z);
    end

    always_comb
    begin
        dot      = 34'(pxx_reg) + 34'(pyy_reg) + 34'(pzz_reg);
        dot_mag  = dot[33] ? 34'(-dot) : 34'(dot);
        cm_next  = cos_scale(dot_mag);
        // cosine is minus the dot product
        neg_next = !dot[33] && (dot != '0);
    end

    always_comb
    begin
        side3_next.c30         = neg_reg ? (32'd0 - {1'b0, cm_reg}) : {1'b0, cm_reg};
        side3_next.n1          = n1_2_reg;
        side3_next.n2          = n2_2_reg;
        side3_next.flg.n2_zero = (n2_2_reg == '0);
        side3_next.flg.tir     = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxx_reg    <= pxx_next;
            pyy_reg    <= pyy_next;
            pzz_reg    <= pzz_next;
            n1_1_reg   <= item_reg.index_incident;
            n2_1_reg   <= item_reg.index_transmit;
            cm_reg     <= cm_next;
            neg_reg    <= neg_next;
            n1_2_reg   <= n1_1_reg;
            n2_2_reg   <= n2_1_reg;
            c2full_reg <= {31'd0, cm_reg} * {31'd0, cm_reg};
            n1sq3_reg  <= n1_2_reg * n1_2_reg;
            n2sq3_reg  <= n2_2_reg * n2_2_reg;
            side3_reg  <= side3_next;
            om_reg     <= ONE30 - c2full_reg[60:30];
            n1sq4_reg  <= n1sq3_reg;
            n2sq4_reg  <= n2sq3_reg;
            side4_reg  <= side3_reg;
            numr5_reg  <= {31'd0, n1sq4_reg} * {30'd0, om_reg};
            den5_reg   <= n2sq4_reg;
            side5_reg  <= side4_reg;
        end
    end

    // ---------------- sine squared divider, one quotient bit per stage
    logic        d1_v_reg [0:QBITS];
    logic [60:0] d1_r_reg [0:QBITS];
    logic [30:0] d1_q_reg [0:QBITS];
    logic [29:0] d1_d_reg [0:QBITS];
    side_t       d1_s_reg [0:QBITS];

    logic [60:0] tir_bound;
    side_t       d1_side_next;

    always_comb
    begin
        // quotient above one exactly when numerator reaches (2^30 + 1) * den
        tir_bound            = (61'(den5_reg) << 30) + 61'(den5_reg);
        d1_side_next         = side5_reg;
        d1_side_next.flg.tir = numr5_reg >= tir_bound;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            d1_v_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_r_reg[0] <= numr5_reg;
            d1_q_reg[0] <= '0;
            d1_d_reg[0] <= den5_reg;
            d1_s_reg[0] <= d1_side_next;
        end
    end

    for (genvar k = 0; k < QBITS; k++)
    begin : g_qdiv
        localparam int SH = QBITS - 1 - k;
        logic [60:0] trial;
        logic        take;
        logic [60:0] r_next;
        logic [30:0] q_next;

        always_comb
        begin
            trial  = 61'(d1_d_reg[k]) << SH;
            take   = d1_r_reg[k] >= trial;
            r_next = take ? (d1_r_reg[k] - trial) : d1_r_reg[k];
            q_next = {d1_q_reg[k][29:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                d1_v_reg[k+1] <= d1_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_r_reg[k+1] <= r_next;
                d1_q_reg[k+1] <= q_next;
                d1_d_reg[k+1] <= d1_d_reg[k];
                d1_s_reg[k+1] <= d1_s_reg[k];
            end
        end
    end

    // ---------------- transmitted cosine
    logic [30:0] one_minus_s2;
    logic [60:0] rad;
    logic        sq_valid;
    logic [30:0] sq_root;
    side_t       sq_side;

    assign one_minus_s2 = ONE30 - d1_q_reg[QBITS];
    assign rad          = {one_minus_s2[30:0], 30'd0};

    frsl_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_v_reg[QBITS]),
        .in_rad    (rad),
        .in_side   (d1_s_reg[QBITS]),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- amplitude ratio numerators and denominators
    logic               vp_reg, vs_reg, vm_reg;
    flags_t             fp_reg, fs_reg, fm_reg;
    logic signed [47:0] pa1_reg, pb1_reg, pa2_reg, pb2_reg;
    logic signed [48:0] num1_reg, den1_reg, num2_reg, den2_reg;
    logic [47:0]        an_reg [0:1];
    logic [47:0]        ad_reg [0:1];

    logic signed [15:0] n1e, n2e;
    logic signed [31:0] ce, te;
    logic signed [47:0] pa1_next, pb1_next, pa2_next, pb2_next;
    logic [48:0]        mag_num1, mag_den1, mag_num2, mag_den2;

    always_comb
    begin
        n1e      = $signed({1'b0, sq_side.n1});
        n2e      = $signed({1'b0, sq_side.n2});
        ce       = $signed(sq_side.c30);
        te       = $signed({1'b0, sq_root});
        pa1_next = n1e * ce;
        pb1_next = n2e * te;
        pa2_next = n2e * ce;
        pb2_next = n1e * te;
    end

    always_comb
    begin
        mag_num1 = num1_reg[48] ? 49'(-num1_reg) : 49'(num1_reg);
        mag_den1 = den1_reg[48] ? 49'(-den1_reg) : 49'(den1_reg);
        mag_num2 = num2_reg[48] ? 49'(-num2_reg) : 49'(num2_reg);
        mag_den2 = den2_reg[48] ? 49'(-den2_reg) : 49'(den2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vs_reg <= 1'b0;
            vm_reg <= 1'b0;
        end
        else if (adv)
        begin
            vp_reg <= sq_valid;
            vs_reg <= vp_reg;
            vm_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            fp_reg    <= sq_side.flg;
            num1_reg  <= 49'(pa1_reg) - 49'(pb1_reg);
            den1_reg  <= 49'(pa1_reg) + 49'(pb1_reg);
            num2_reg  <= 49'(pa2_reg) - 49'(pb2_reg);
            den2_reg  <= 49'(pa2_reg) + 49'(pb2_reg);
            fs_reg    <= fp_reg;
            an_reg[0] <= mag_num1[47:0];
            ad_reg[0] <= mag_den1[47:0];
            an_reg[1] <= mag_num2[47:0];
            ad_reg[1] <= mag_den2[47:0];
            fm_reg    <= fs_reg;
        end
    end

    // ---------------- ratio dividers, two lanes, one quotient bit per stage
    logic        r2_v_reg    [0:RBITS];
    flags_t      r2_f_reg    [0:RBITS];
    logic [47:0] r2_rem_reg  [0:RBITS][0:1];
    logic [47:0] r2_d_reg    [0:RBITS][0:1];
    logic [14:0] r2_q_reg    [0:RBITS][0:1];
    logic        r2_sat_reg  [0:RBITS][0:1];
    logic        r2_zero_reg [0:RBITS][0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            r2_v_reg[0] <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_f_reg[0] <= fm_reg;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r2_rem_reg[0][l]  <= an_reg[l];
                r2_d_reg[0][l]    <= ad_reg[l];
                r2_q_reg[0][l]    <= '0;
                r2_sat_reg[0][l]  <= an_reg[l] >= ad_reg[l];
                r2_zero_reg[0][l] <= (ad_reg[l] == '0);
            end
        end

        for (genvar k = 0; k < RBITS; k++)
        begin : g_rstep
            logic [48:0] rem2;
            logic        take;
            logic [47:0] rem_next;
            logic [14:0] q_next;

            always_comb
            begin
                rem2     = {r2_rem_reg[k][l], 1'b0};
                take     = rem2 >= {1'b0, r2_d_reg[k][l]};
                rem_next = take ? 48'(rem2 - {1'b0, r2_d_reg[k][l]}) : rem2[47:0];
                q_next   = {r2_q_reg[k][l][13:0], take};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r2_rem_reg[k+1][l]  <= rem_next;
                    r2_d_reg[k+1][l]    <= r2_d_reg[k][l];
                    r2_q_reg[k+1][l]    <= q_next;
                    r2_sat_reg[k+1][l]  <= r2_sat_reg[k][l];
                    r2_zero_reg[k+1][l] <= r2_zero_reg[k][l];
                end
            end
        end
    end

    for (genvar k = 0; k < RBITS; k++)
    begin : g_rvalid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                r2_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                r2_v_reg[k+1] <= r2_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r2_f_reg[k+1] <= r2_f_reg[k];
            end
        end
    end

    // ---------------- ratio select, square, average
    logic        vq_reg, vsq_reg;
    flags_t      fq_reg, fsq_reg;
    logic        zq_reg, zsq_reg;
    logic [15:0] q_reg  [0:1];
    logic [15:0] sq_reg [0:1];

    logic [15:0] q_next  [0:1];
    logic [31:0] qq      [0:1];
    logic [16:0] avg_sum;
    result_t     result_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            q_next[l] = r2_sat_reg[RBITS][l] ? ONE15 : {1'b0, r2_q_reg[RBITS][l]};
            qq[l]     = q_reg[l] * q_reg[l];
        end
    end

    always_comb
    begin
        avg_sum = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
        result_next.total_internal = 1'b0;
        priority if (fsq_reg.n2_zero)
        begin
            result_next.reflectance = ONE15;
        end
        else if (fsq_reg.tir)
        begin
            result_next.reflectance    = ONE15;
            result_next.total_internal = 1'b1;
        end
        else if (zsq_reg)
        begin
            result_next.reflectance = ONE15;
        end
        else
        begin
            result_next.reflectance = avg_sum[16:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg           <= 1'b0;
            vsq_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vq_reg           <= r2_v_reg[RBITS];
            vsq_reg          <= vq_reg;
            result_valid_reg <= vsq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0]   <= q_next[0];
            q_reg[1]   <= q_next[1];
            fq_reg     <= r2_f_reg[RBITS];
            zq_reg     <= r2_zero_reg[RBITS][0] || r2_zero_reg[RBITS][1];
            sq_reg[0]  <= qq[0][30:15];
            sq_reg[1]  <= qq[1][30:15];
            fsq_reg    <= fq_reg;
            zsq_reg    <= zq_reg;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- checks
    a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.reflectance <= ONE15))
        else $error("reflectance above one");

    a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.total_internal) |-> (result.reflectance == ONE15))
        else $error("total internal reflection without full reflectance");

    a_s2_range: assert property (@(posedge clk) disable iff (!rst_n)
        (d1_v_reg[QBITS] && !d1_s_reg[QBITS].flg.tir && !d1_s_reg[QBITS].flg.n2_zero)
        |-> (d1_q_reg[QBITS] <= ONE30))
        else $error("sine squared quotient above one without tir flag");

    // root of a flagged ray is meaningless and not checked
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid && !sq_side.flg.tir && !sq_side.flg.n2_zero)
        |-> (sq_root <= ONE30))
        else $error("transmitted cosine above one");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && !adv) |=> v0_reg)
        else $error("held input beat dropped during stall");

endmodule
